/* hdl/pfxeval_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
// No dependencies; used by every module under hdl/ except pfxeval_ram.
package pfxeval_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 5;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic    capture;
        logic    push;
        logic    rd_lhs;
        logic    exec;
        logic    mul_fin;
        logic    div_step;
        logic    div_fin;
        logic    commit;
        logic    emit;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_space;
        logic is_op;
        t_op  op;
        logic full;
        logic lt2;
        logic rhs_zero;
        logic div_last;
    } t_stat;

endpackage

/* hdl/pfxeval_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfxeval_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/pfxeval_ctrl.sv */
// Sequencing state machine for the postfix evaluator.
// Depends on pfxeval_pkg; drives the datapath through t_cmd, reads t_stat.
module pfxeval_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  pfxeval_pkg::t_stat  i_stat,
    output pfxeval_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIN,
        S_COMMIT,
        S_EMIT
    } t_state;

    t_state               r_state, n_state;
    pfxeval_pkg::t_status r_status, n_status;
    logic                 r_o_valid, n_o_valid;
    pfxeval_pkg::t_cmd    cmd;

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_o_valid  = r_o_valid;
        cmd        = '0;
        cmd.status = r_status;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_EMIT;
                n_status = pfxeval_pkg::ST_OK;
                if (i_stat.is_digit) begin
                    if (i_stat.full) begin
                        n_status = pfxeval_pkg::ST_OVER;
                    end else begin
                        cmd.push = 1'b1;
                    end
                end else if (i_stat.is_space) begin
                    n_status = pfxeval_pkg::ST_OK;
                end else if (i_stat.is_op) begin
                    if (i_stat.lt2) begin
                        n_status = pfxeval_pkg::ST_UNDER;
                    end else if (i_stat.op == pfxeval_pkg::OP_DIV && i_stat.rhs_zero) begin
                        n_status = pfxeval_pkg::ST_DIVZERO;
                    end else begin
                        cmd.rd_lhs = 1'b1;
                        n_state    = S_EXEC;
                    end
                end else begin
                    n_status = pfxeval_pkg::ST_INVALID;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                case (i_stat.op)
                    pfxeval_pkg::OP_MUL: n_state = S_MUL;
                    pfxeval_pkg::OP_DIV: n_state = S_DIV;
                    default:             n_state = S_COMMIT;
                endcase
            end
            S_MUL: begin
                cmd.mul_fin = 1'b1;
                n_state     = S_COMMIT;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DIVFIN;
                end
            end
            S_DIVFIN: begin
                cmd.div_fin = 1'b1;
                n_state     = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    cmd.emit  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= pfxeval_pkg::ST_OK;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_cmd   = cmd;

endmodule

/* hdl/pfxeval_dp.sv */
// Datapath: operand stack, cached top, add/sub, multiplier, serial divider,
// output register. Depends on pfxeval_pkg and pfxeval_ram.
module pfxeval_dp #(
    parameter int STACK_DEPTH = pfxeval_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = pfxeval_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [7:0]                           i_char_code,
    input  pfxeval_pkg::t_cmd                    i_cmd,
    output pfxeval_pkg::t_stat                   o_stat,
    output logic signed [pfxeval_pkg::DATA_W-1:0] o_top_value,
    output logic [pfxeval_pkg::COUNT_W-1:0]      o_stack_count,
    output logic [2:0]                           o_status
);

    localparam int DW  = pfxeval_pkg::DATA_W;
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int QW  = DW + FRAC_BITS;
    localparam int CW  = $clog2(QW);
    localparam logic signed [2*DW-1:0] MAX64 = 64'sd2147483647;
    localparam logic signed [2*DW-1:0] MIN64 = -64'sd2147483648;

    logic [7:0]                r_char;
    logic [PW-1:0]             r_sp;
    logic [DW-1:0]             r_top;
    logic [DW-1:0]             r_res;
    logic signed [2*DW-1:0]    r_prod;
    logic [QW-1:0]             r_quo;
    logic [DW-1:0]             r_rem;
    logic [DW-1:0]             r_dvs;
    logic                      r_sign;
    logic [CW-1:0]             r_cnt;
    logic [DW-1:0]             r_out_top;
    logic [pfxeval_pkg::COUNT_W-1:0] r_out_cnt;
    pfxeval_pkg::t_status      r_out_status;

    pfxeval_pkg::t_stat stat;
    logic [3:0]         dig;
    logic [DW-1:0]      digit_val;
    logic [DW-1:0]      lhs;
    logic [DW:0]        sum_c, dif_c;
    logic [DW-1:0]      add_sat, sub_sat;
    logic signed [2*DW-1:0] mul_shr;
    logic [DW-1:0]      mul_sat;
    logic [DW-1:0]      lhs_mag, rhs_mag;
    logic [DW:0]        rem_sh;
    logic               ge;
    logic [DW-1:0]      div_sat;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DW-1:0]      ram_wdata;

    pfxeval_ram #(
        .WIDTH(DW),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd_lhs),
        .i_raddr(AW'(r_sp - PW'(2))),
        .o_rdata(lhs)
    );

    assign ram_we    = i_cmd.push | i_cmd.commit;
    assign ram_waddr = i_cmd.push ? AW'(r_sp) : AW'(r_sp - PW'(2));
    assign ram_wdata = i_cmd.push ? digit_val : r_res;

    assign dig       = 4'(r_char - pfxeval_pkg::CHR_ZERO);
    assign digit_val = DW'(dig) << FRAC_BITS;

    always_comb begin
        stat          = '0;
        stat.is_digit = (r_char >= pfxeval_pkg::CHR_ZERO) && (r_char <= pfxeval_pkg::CHR_NINE);
        stat.is_space = (r_char == pfxeval_pkg::CHR_SPACE);
        stat.op       = pfxeval_pkg::OP_ADD;
        case (r_char)
            pfxeval_pkg::CHR_PLUS: begin
                stat.is_op = 1'b1;
                stat.op    = pfxeval_pkg::OP_ADD;
            end
            pfxeval_pkg::CHR_MINUS: begin
                stat.is_op = 1'b1;
                stat.op    = pfxeval_pkg::OP_SUB;
            end
            pfxeval_pkg::CHR_STAR: begin
                stat.is_op = 1'b1;
                stat.op    = pfxeval_pkg::OP_MUL;
            end
            pfxeval_pkg::CHR_SLASH: begin
                stat.is_op = 1'b1;
                stat.op    = pfxeval_pkg::OP_DIV;
            end
            default: begin
                stat.is_op = 1'b0;
            end
        endcase
        stat.full     = (r_sp >= PW'(STACK_DEPTH));
        stat.lt2      = (r_sp < PW'(2));
        stat.rhs_zero = (r_top == '0);
        stat.div_last = (r_cnt == CW'(QW - 1));
    end

    // add / sub with saturation
    assign sum_c   = {lhs[DW-1], lhs} + {r_top[DW-1], r_top};
    assign dif_c   = {lhs[DW-1], lhs} - {r_top[DW-1], r_top};
    assign add_sat = (sum_c[DW] != sum_c[DW-1]) ?
                     (sum_c[DW] ? pfxeval_pkg::SAT_MIN : pfxeval_pkg::SAT_MAX) : sum_c[DW-1:0];
    assign sub_sat = (dif_c[DW] != dif_c[DW-1]) ?
                     (dif_c[DW] ? pfxeval_pkg::SAT_MIN : pfxeval_pkg::SAT_MAX) : dif_c[DW-1:0];

    // product: arithmetic shift is floor
    assign mul_shr = r_prod >>> FRAC_BITS;
    always_comb begin
        if (mul_shr > MAX64) begin
            mul_sat = pfxeval_pkg::SAT_MAX;
        end else if (mul_shr < MIN64) begin
            mul_sat = pfxeval_pkg::SAT_MIN;
        end else begin
            mul_sat = mul_shr[DW-1:0];
        end
    end

    // restoring divider on magnitudes, one quotient bit per cycle
    assign lhs_mag = lhs[DW-1] ? DW'(-lhs) : lhs;
    assign rhs_mag = r_top[DW-1] ? DW'(-r_top) : r_top;
    assign rem_sh  = {r_rem, r_quo[QW-1]};
    assign ge      = (rem_sh >= {1'b0, r_dvs});

    always_comb begin
        if (r_sign) begin
            if (r_quo > (QW'(1) << (DW - 1))) begin
                div_sat = pfxeval_pkg::SAT_MIN;
            end else begin
                div_sat = DW'(-r_quo[DW-1:0]);
            end
        end else if (r_quo > QW'(pfxeval_pkg::SAT_MAX)) begin
            div_sat = pfxeval_pkg::SAT_MAX;
        end else begin
            div_sat = r_quo[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.push) begin
            r_sp <= r_sp + PW'(1);
        end else if (i_cmd.commit) begin
            r_sp <= r_sp - PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_char <= i_char_code;
        end
        if (i_cmd.push) begin
            r_top <= digit_val;
        end else if (i_cmd.commit) begin
            r_top <= r_res;
        end
        if (i_cmd.exec) begin
            r_res  <= (stat.op == pfxeval_pkg::OP_SUB) ? sub_sat : add_sat;
            r_prod <= $signed(lhs) * $signed(r_top);
            r_quo  <= QW'(lhs_mag) << FRAC_BITS;
            r_rem  <= '0;
            r_dvs  <= rhs_mag;
            r_sign <= lhs[DW-1] ^ r_top[DW-1];
            r_cnt  <= '0;
        end
        if (i_cmd.mul_fin) begin
            r_res <= mul_sat;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? DW'(rem_sh - {1'b0, r_dvs}) : rem_sh[DW-1:0];
            r_quo <= {r_quo[QW-2:0], ge};
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.div_fin) begin
            r_res <= div_sat;
        end
        if (i_cmd.emit) begin
            r_out_top    <= (r_sp != '0) ? r_top : '0;
            r_out_cnt    <= pfxeval_pkg::COUNT_W'(r_sp);
            r_out_status <= i_cmd.status;
        end
    end

    assign o_stat        = stat;
    assign o_top_value   = r_out_top;
    assign o_stack_count = r_out_cnt;
    assign o_status      = r_out_status;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !stat.full && stat.is_digit)
        else $error("push on full stack or non-digit");

    a_commit_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !stat.lt2 ##1 (r_sp == $past(r_sp) - PW'(1)))
        else $error("operator commit did not pop one entry");

endmodule

/* hdl/postfix_expression_evaluator.sv */
// Top level of the postfix (RPN) evaluator over signed fixed-point values.
// Depends on pfxeval_pkg, pfxeval_ctrl, pfxeval_dp (which holds pfxeval_ram).
//
//  channel   dir  handshake           payload
//  input     in   i_valid / o_ready   i_char_code[7:0]
//  output    out  o_valid / i_ready   o_top_value[31:0], o_stack_count[4:0], o_status[2:0]
//
// Digit, space, invalid char or any error: IDLE, DECODE, EMIT; one request at a time.
// Add/sub: IDLE, DECODE, EXEC, COMMIT, EMIT; multiply adds MUL between EXEC and COMMIT.
// Divide: EXEC, DIV (one quotient bit per cycle), DIVFIN, COMMIT; Q16.16 by default.
// Reset empties the stack pointer; stack memory is not cleared.
// Result sits in an output register; the next request is taken while it waits.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfxeval_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = pfxeval_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [7:0]                            i_char_code,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [pfxeval_pkg::DATA_W-1:0] o_top_value,
    output logic [pfxeval_pkg::COUNT_W-1:0]       o_stack_count,
    output logic [2:0]                            o_status
);

    pfxeval_pkg::t_cmd  cmd;
    pfxeval_pkg::t_stat stat;

    pfxeval_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    pfxeval_dp #(
        .STACK_DEPTH(STACK_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_code  (i_char_code),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_top_value  (o_top_value),
        .o_stack_count(o_stack_count),
        .o_status     (o_status)
    );

endmodule
